>>> rtl/core/pow2_shelf_rect_allocator_assert.svh
// Assertion macros for the power-of-two shelf rectangle allocator.
`ifndef POW2_SHELF_RECT_ALLOCATOR_ASSERT_SVH
`define POW2_SHELF_RECT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define P2SRA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("p2sra assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define P2SRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("p2sra assertion failed");

`endif

>>> rtl/core/p2sra_pkg.sv
// Package with shared types and constants of the shelf rectangle allocator.
`default_nettype none

package p2sra_pkg;

  localparam int unsigned FIELD_W    = 15;
  localparam int unsigned AREA_W     = 30;
  localparam int unsigned CLASS_BITS = 4;
  localparam int unsigned SUM_W      = FIELD_W + 2;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;

  localparam int unsigned ROW_CLASSES_DEF = 16;
  localparam int unsigned COORD_BITS_DEF  = 16;

  localparam logic [AREA_W-1:0]     AREA_MAX    = '1;
  localparam logic [FIELD_W-1:0]    ATLAS_RESET = 15'd256;
  localparam logic [CLASS_BITS-1:0] MIN_CLASS   = 4'd1;

  localparam logic [ADDR_W-1:0] ADDR_ATLAS_WIDTH  = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_ATLAS_HEIGHT = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic eval;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] height;
  } atlas_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/p2sra_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface p2sra_req_if import p2sra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] rect_width;
  logic [FIELD_W-1:0] rect_height;

  modport source (output valid, output rect_width, output rect_height, input ready);
  modport sink (input valid, input rect_width, input rect_height, output ready);
endinterface

interface p2sra_rsp_if import p2sra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               placed;
  logic [FIELD_W-1:0] place_x;
  logic [FIELD_W-1:0] place_y;
  logic [AREA_W-1:0]  area_used;

  modport source (output valid, output placed, output place_x, output place_y,
                  output area_used, input ready);
  modport sink (input valid, input placed, input place_x, input place_y,
                input area_used, output ready);
endinterface

`default_nettype wire

>>> rtl/core/p2sra_cfg.sv
// APB-style configuration registers holding the atlas size.
`default_nettype none

module p2sra_cfg import p2sra_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output atlas_cfg_t        cfg_o
);

  logic               wr_en;
  logic [FIELD_W-1:0] width_q, width_d;
  logic [FIELD_W-1:0] height_q, height_d;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en && (paddr == ADDR_ATLAS_WIDTH)) begin
      width_d = pwdata[FIELD_W-1:0];
    end
    if (wr_en && (paddr == ADDR_ATLAS_HEIGHT)) begin
      height_d = pwdata[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ATLAS_RESET;
      height_q <= ATLAS_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ATLAS_WIDTH) begin
      prdata = DATA_W'(width_q);
    end else if (paddr == ADDR_ATLAS_HEIGHT) begin
      prdata = DATA_W'(height_q);
    end
  end

  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;

endmodule

`default_nettype wire

>>> rtl/core/p2sra_ctrl.sv
// Controller state machine that sequences one request through the datapath.
`default_nettype none

module p2sra_ctrl import p2sra_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
      end
      ST_COMMIT: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/p2sra_dpath.sv
// Datapath with row class encoder, area multiplier, row register file and result register.
`default_nettype none

module p2sra_dpath import p2sra_pkg::*; #(
  parameter int unsigned ROW_CLASSES = ROW_CLASSES_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  atlas_cfg_t         cfg_i,
  input  logic [FIELD_W-1:0] rect_width_i,
  input  logic [FIELD_W-1:0] rect_height_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               placed_o,
  output logic [FIELD_W-1:0] place_x_o,
  output logic [FIELD_W-1:0] place_y_o,
  output logic [AREA_W-1:0]  area_used_o
);

  localparam int unsigned IDX_W = (ROW_CLASSES > 1) ? $clog2(ROW_CLASSES) : 1;

  logic [FIELD_W-1:0]    w_q, h_q;
  logic [CLASS_BITS-1:0] cls_q, cls_d;
  logic                  cls_ok_q, cls_ok_d;
  logic [FIELD_W:0]      ph_q, ph_d;
  logic [AREA_W-1:0]     prod_q;
  logic                  fit_q, fit_d;

  logic [COORD_BITS-1:0] cursor_q [ROW_CLASSES];
  logic [COORD_BITS-1:0] top_q [ROW_CLASSES];
  logic [ROW_CLASSES-1:0] open_q;
  logic [COORD_BITS-1:0] next_y_q, next_y_d;
  logic [AREA_W-1:0]     area_q, area_d;

  logic                  out_valid_q;
  logic                  placed_q;
  logic [FIELD_W-1:0]    place_x_q, place_y_q;

  logic [IDX_W-1:0]      idx;
  logic                  need_strip;
  logic                  ok;
  logic [COORD_BITS-1:0] pos_x, pos_y;
  logic [SUM_W-1:0]      pos_x_ext, pos_y_ext;
  logic [SUM_W-1:0]      cursor_sum;
  logic [SUM_W-1:0]      strip_sum;
  logic [AREA_W:0]       area_sum;

  always_comb begin
    logic [FIELD_W-1:0]    hm1;
    logic [CLASS_BITS-1:0] len;
    hm1 = (h_q > FIELD_W'(1)) ? (h_q - FIELD_W'(1)) : '0;
    len = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (hm1[i]) begin
        len = CLASS_BITS'(i + 1);
      end
    end
    cls_d    = (len < MIN_CLASS) ? MIN_CLASS : len;
    ph_d     = (FIELD_W + 1)'(1) << cls_d;
    cls_ok_d = ({1'b0, cls_d} < (CLASS_BITS + 1)'(ROW_CLASSES));
    fit_d    = (w_q <= cfg_i.width) && (h_q <= cfg_i.height);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q <= rect_width_i;
      h_q <= rect_height_i;
    end
    if (cmd_i.eval) begin
      cls_q    <= cls_d;
      cls_ok_q <= cls_ok_d;
      ph_q     <= ph_d;
      fit_q    <= fit_d;
      prod_q   <= AREA_W'(w_q) * AREA_W'(h_q);
    end
  end

  assign idx        = cls_q[IDX_W-1:0];
  assign cursor_sum = SUM_W'(cursor_q[idx]) + SUM_W'(w_q);
  assign strip_sum  = SUM_W'(next_y_q) + SUM_W'(ph_q);
  assign need_strip = !open_q[idx] || (cursor_sum > SUM_W'(cfg_i.width));
  assign ok         = fit_q && cls_ok_q && (!need_strip || (strip_sum <= SUM_W'(cfg_i.height)));
  assign pos_x      = need_strip ? '0 : cursor_q[idx];
  assign pos_y      = need_strip ? next_y_q : top_q[idx];
  assign pos_x_ext  = SUM_W'(pos_x);
  assign pos_y_ext  = SUM_W'(pos_y);
  assign area_sum   = {1'b0, area_q} + {1'b0, prod_q};

  always_comb begin
    logic [SUM_W-1:0] strip_next;
    strip_next = SUM_W'(next_y_q) + SUM_W'(ph_q);
    next_y_d   = next_y_q;
    area_d     = area_q;
    if (cmd_i.commit && ok) begin
      if (need_strip) begin
        next_y_d = strip_next[COORD_BITS-1:0];
      end
      area_d = (area_sum > {1'b0, AREA_MAX}) ? AREA_MAX : area_sum[AREA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= '0;
      next_y_q <= '0;
      area_q   <= '0;
    end else begin
      next_y_q <= next_y_d;
      area_q   <= area_d;
      if (cmd_i.commit && ok) begin
        open_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ok) begin
      cursor_q[idx] <= COORD_BITS'(pos_x_ext + SUM_W'(w_q));
      if (need_strip) begin
        top_q[idx] <= next_y_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      placed_q  <= ok;
      place_x_q <= ok ? pos_x_ext[FIELD_W-1:0] : '0;
      place_y_q <= ok ? pos_y_ext[FIELD_W-1:0] : '0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign placed_o          = placed_q;
  assign place_x_o         = place_x_q;
  assign place_y_o         = place_y_q;
  assign area_used_o       = area_q;

endmodule

`default_nettype wire

>>> rtl/core/pow2_shelf_rect_allocator.sv
// Top level of the power-of-two shelf rectangle allocator.
//
//   port     | direction | carries
//   ---------+-----------+------------------------------------------
//   req_i    | sink      | rect_width, rect_height
//   rsp_o    | source    | placed, place_x, place_y, area_used
//   p*       | APB slave | atlas_width at 0x0, atlas_height at 0x4
//
// Each request passes through the transfer, an evaluate state for the height class
// encoder and the 15x15 area multiplier, and a commit state for the
// read-modify-write of the row register file. The commit waits while the result
// register is full and not taken; the next request is accepted once the commit is
// done. Reset clears all rows to unused, the next strip Y and the area at once.
`default_nettype none

module pow2_shelf_rect_allocator import p2sra_pkg::*; #(
  parameter int unsigned ROW_CLASSES = ROW_CLASSES_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  p2sra_req_if.sink         req_i,
  p2sra_rsp_if.source       rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  `include "pow2_shelf_rect_allocator_assert.svh"

  atlas_cfg_t cfg;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  p2sra_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  p2sra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  p2sra_dpath #(
    .ROW_CLASSES (ROW_CLASSES),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .cfg_i         (cfg),
    .rect_width_i  (req_i.rect_width),
    .rect_height_i (req_i.rect_height),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .placed_o      (rsp_o.placed),
    .place_x_o     (rsp_o.place_x),
    .place_y_o     (rsp_o.place_y),
    .area_used_o   (rsp_o.area_used)
  );

  `P2SRA_ASSERT_NEXT(a_busy_after_req, req_i.valid && req_i.ready, !req_i.ready)
  `P2SRA_ASSERT_NEXT(a_commit_shows_result, dp_cmd.commit, rsp_o.valid)
  `P2SRA_ASSERT_SAME(a_refused_zero_xy, rsp_o.valid && !rsp_o.placed, (rsp_o.place_x == '0) && (rsp_o.place_y == '0))
  `P2SRA_ASSERT_SAME(a_one_command, 1'b1, $onehot0(dp_cmd))

endmodule

`default_nettype wire
